// ----- sv/crtp_pkg.sv -----
// ----------------------------------------------------------------------------
// crtp_pkg
// shared types, widths and codes of the call/return time profiler
// ----------------------------------------------------------------------------
package crtp_pkg;

  localparam int STACK_DEPTH    = 64;
  localparam int RECORD_ENTRIES = 64;
  localparam int TIME_BITS      = 48;
  localparam int STK_AW         = $clog2(STACK_DEPTH);
  localparam int REC_AW         = $clog2(RECORD_ENTRIES);
  localparam int FID_W          = 32;
  localparam int LINE_W         = 16;
  localparam int CALL_W         = 32;
  localparam int IDX_W          = 6;
  localparam int CNT_W          = 7;

  localparam logic [2:0] OP_CALL   = 3'd0;
  localparam logic [2:0] OP_TAIL   = 3'd1;
  localparam logic [2:0] OP_RETURN = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_BEGIN  = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_STK_FULL = 3'd2;
  localparam logic [2:0] ST_NO_MATCH = 3'd3;
  localparam logic [2:0] ST_TBL_FULL = 3'd4;
  localparam logic [2:0] ST_BAD_IDX  = 3'd5;

  localparam logic [1:0] CFG_ENABLED   = 2'd0;
  localparam logic [1:0] CFG_YIELD_FID = 2'd1;
  localparam logic [1:0] CFG_TRACE     = 2'd2;

  typedef struct packed {
    logic [FID_W-1:0]     fn;
    logic [LINE_W-1:0]    line;
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] child;
    logic [TIME_BITS-1:0] yld;
    logic                 tail;
  } frame_t;

  typedef struct packed {
    logic [FID_W-1:0]     fn;
    logic [LINE_W-1:0]    line;
    logic [CALL_W-1:0]    calls;
    logic [TIME_BITS-1:0] total;
    logic [TIME_BITS-1:0] self_t;
    logic [TIME_BITS-1:0] coro;
    logic                 tail;
  } rec_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] a;
    logic [TIME_BITS-1:0] b;
    logic                 sub;
  } alu_req_t;

endpackage

// ----- sv/crtp_ram.sv -----
// ----------------------------------------------------------------------------
// crtp_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module crtp_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/crtp_alu.sv -----
// ----------------------------------------------------------------------------
// crtp_alu
// shared time adder/subtractor, wraps modulo 2^TIME_BITS
// ----------------------------------------------------------------------------
module crtp_alu (
  input  crtp_pkg::alu_req_t                req,
  output logic [crtp_pkg::TIME_BITS-1:0]    y
);

  assign y = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

// ----- sv/call_return_time_profiler.sv -----
// ----------------------------------------------------------------------------
// call_return_time_profiler
// frame stack and per-function record table driven by call/return events
// ----------------------------------------------------------------------------
// One event is taken at a time; in_tready is high only while the sequencer
// is idle. A return pops frames until one matches the returning id, then for
// each frame charged (one, or a whole tail chain in trace mode) scans the
// record table entry by entry, also adding to the yield time when the
// returning id is the yield id; all time arithmetic goes through the single
// shared 48-bit adder, and the frame and record rams each have one read
// port. A result may wait in the output register while the next event is
// taken.
module call_return_time_profiler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // function_id, def_line, event_time, record_index
  input  logic [2:0]   in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  // rec_function_id, rec_line, rec_calls, rec_total_time, rec_self_time,
  // rec_coroutine_time, rec_tail_seen, entries_used, sum_self_time,
  // sum_yield_time
  output logic [327:0] out_tdata,
  output logic [2:0]   out_tuser,  // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int T  = crtp_pkg::TIME_BITS;
  localparam int SW = crtp_pkg::STK_AW;
  localparam int RW = crtp_pkg::REC_AW;

  typedef enum logic [25:0] {
    S_IDLE  = 26'h0000001, S_DISP  = 26'h0000002, S_PUSH  = 26'h0000004,
    S_TRD   = 26'h0000008, S_TWR   = 26'h0000010, S_RRD   = 26'h0000020,
    S_POP   = 26'h0000040, S_PCMP  = 26'h0000080, S_TOT   = 26'h0000100,
    S_SELF  = 26'h0000200, S_YLD   = 26'h0000400, S_YSUM  = 26'h0000800,
    S_RSRCH = 26'h0001000, S_RCMP  = 26'h0002000, S_CALLS = 26'h0004000,
    S_RTOT  = 26'h0008000, S_RSELF = 26'h0010000, S_COR1  = 26'h0020000,
    S_COR2  = 26'h0040000, S_WREC  = 26'h0080000, S_PAR   = 26'h0100000,
    S_PLD   = 26'h0200000, S_PYL   = 26'h0400000, S_PWR   = 26'h0800000,
    S_SSUM  = 26'h1000000, S_DONE  = 26'h2000000
  } state_t;

  state_t state_r;

  logic                              en_r, trace_r;
  logic [crtp_pkg::FID_W-1:0]        yid_r;
  logic [SW:0]                       depth_r;
  logic [RW:0]                       cnt_r, ri_r;
  logic [T-1:0]                      ssum_r, ysum_r, total_r, self_r;
  logic [2:0]                        op_r, st_r;
  logic [crtp_pkg::FID_W-1:0]        fid_r;
  logic [crtp_pkg::LINE_W-1:0]       line_r;
  logic [T-1:0]                      time_r;
  logic [crtp_pkg::IDX_W-1:0]        idx_r;
  crtp_pkg::frame_t                  cur_r, par_r, fm_wdata, fm_rdata;
  crtp_pkg::rec_t                    rec_r, rd_rec_r, rm_wdata, rm_rdata;
  logic                              out_valid_r;
  logic [327:0]                      out_data_r;
  logic [2:0]                        out_st_r;
  logic                              fm_we, rm_we;
  logic [SW-1:0]                     fm_waddr, top_addr;
  logic [RW-1:0]                     rm_raddr;
  logic [SW:0]                       depth_m1;
  crtp_pkg::alu_req_t                alu_req;
  logic [T-1:0]                      alu_y;
  logic                              stk_full, yield_hit;

  function automatic logic [crtp_pkg::CNT_W-1:0] CNT_EXT(input logic [RW:0] c);
    CNT_EXT = crtp_pkg::CNT_W'(c);
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

  assign depth_m1  = depth_r - (SW+1)'(1);
  assign top_addr  = depth_m1[SW-1:0];
  assign stk_full  = (depth_r >= (SW+1)'(crtp_pkg::STACK_DEPTH));
  assign yield_hit = (fid_r == yid_r);
  assign rm_raddr  = (state_r == S_DISP) ? idx_r[RW-1:0] : ri_r[RW-1:0];

  crtp_ram #(.WIDTH($bits(crtp_pkg::frame_t)), .AW(SW)) u_frames (
    .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
    .raddr(top_addr), .rdata(fm_rdata)
  );

  crtp_ram #(.WIDTH($bits(crtp_pkg::rec_t)), .AW(RW)) u_records (
    .clk(clk), .we(rm_we), .waddr(ri_r[RW-1:0]), .wdata(rm_wdata),
    .raddr(rm_raddr), .rdata(rm_rdata)
  );

  crtp_alu u_alu (.req(alu_req), .y(alu_y));

  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = top_addr;
    fm_wdata = par_r;
    rm_we    = (state_r == S_WREC);
    rm_wdata = rec_r;
    unique case (state_r)
      S_PUSH: begin
        fm_we    = 1'b1;
        fm_waddr = depth_r[SW-1:0];
        fm_wdata = '{fn: fid_r, line: line_r, start: time_r, child: '0, yld: '0,
                     tail: (op_r == crtp_pkg::OP_TAIL)};
      end
      S_TWR: begin
        fm_we    = 1'b1;
        fm_wdata = cur_r;
      end
      S_PWR: fm_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    alu_req = '{a: '0, b: '0, sub: 1'b0};
    unique case (state_r)
      S_TOT:   alu_req = '{a: time_r, b: cur_r.start, sub: 1'b1};
      S_SELF:  alu_req = '{a: total_r, b: cur_r.child, sub: 1'b1};
      S_YLD:   alu_req = '{a: cur_r.yld, b: self_r, sub: 1'b0};
      S_YSUM:  alu_req = '{a: ysum_r, b: self_r, sub: 1'b0};
      S_CALLS: alu_req = '{a: T'(rec_r.calls), b: T'(1), sub: 1'b0};
      S_RTOT:  alu_req = '{a: rec_r.total, b: total_r, sub: 1'b0};
      S_RSELF: alu_req = '{a: rec_r.self_t, b: self_r, sub: 1'b0};
      S_COR1:  alu_req = '{a: rec_r.coro, b: total_r, sub: 1'b0};
      S_COR2:  alu_req = '{a: rec_r.coro, b: cur_r.yld, sub: 1'b1};
      S_PLD:   alu_req = '{a: fm_rdata.child, b: total_r, sub: 1'b0};
      S_PYL:   alu_req = '{a: par_r.yld, b: cur_r.yld, sub: 1'b0};
      S_SSUM:  alu_req = '{a: ssum_r, b: self_r, sub: 1'b0};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= 1'b1;
      yid_r       <= '0;
      trace_r     <= 1'b0;
      depth_r     <= '0;
      cnt_r       <= '0;
      ssum_r      <= '0;
      ysum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          crtp_pkg::CFG_ENABLED:   en_r    <= cfg_data[0];
          crtp_pkg::CFG_YIELD_FID: yid_r   <= cfg_data;
          crtp_pkg::CFG_TRACE:     trace_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r     <= in_tuser;
            fid_r    <= in_tdata[31:0];
            line_r   <= in_tdata[47:32];
            time_r   <= in_tdata[95:48];
            idx_r    <= in_tdata[101:96];
            st_r     <= crtp_pkg::ST_OK;
            rd_rec_r <= '0;
            state_r  <= S_DISP;
          end
        end
        S_DISP: begin
          state_r <= S_DONE;
          if (op_r <= crtp_pkg::OP_RETURN && !en_r) begin
            st_r <= crtp_pkg::ST_DISABLED;
          end else begin
            unique case (op_r)
              crtp_pkg::OP_CALL: begin
                if (stk_full) st_r <= crtp_pkg::ST_STK_FULL;
                else state_r <= S_PUSH;
              end
              crtp_pkg::OP_TAIL: begin
                if (trace_r) begin
                  if (stk_full) st_r <= crtp_pkg::ST_STK_FULL;
                  else state_r <= S_PUSH;
                end else if (depth_r != '0) begin
                  state_r <= S_TRD;
                end
              end
              crtp_pkg::OP_RETURN: state_r <= S_POP;
              crtp_pkg::OP_READ: begin
                if ({1'b0, idx_r} >= CNT_EXT(cnt_r)) st_r <= crtp_pkg::ST_BAD_IDX;
                else state_r <= S_RRD;
              end
              crtp_pkg::OP_CLEAR: begin
                cnt_r  <= '0;
                ssum_r <= '0;
                ysum_r <= '0;
              end
              crtp_pkg::OP_BEGIN: depth_r <= '0;
              default: ;
            endcase
          end
        end
        S_PUSH: begin
          depth_r <= depth_r + (SW+1)'(1);
          state_r <= S_DONE;
        end
        S_TRD: begin
          cur_r   <= '{fn: fid_r, line: line_r, start: fm_rdata.start,
                       child: fm_rdata.child, yld: fm_rdata.yld, tail: 1'b1};
          state_r <= S_TWR;
        end
        S_TWR: state_r <= S_DONE;
        S_RRD: begin
          rd_rec_r <= rm_rdata;
          state_r  <= S_DONE;
        end
        S_POP: begin
          if (depth_r == '0) begin
            st_r    <= crtp_pkg::ST_NO_MATCH;
            state_r <= S_DONE;
          end else begin
            depth_r <= depth_m1;
            state_r <= S_PCMP;
          end
        end
        S_PCMP: begin
          cur_r   <= fm_rdata;
          state_r <= (fm_rdata.fn == fid_r) ? S_TOT : S_POP;
        end
        S_TOT: begin
          total_r <= alu_y;
          ri_r    <= '0;
          state_r <= S_SELF;
        end
        S_SELF: begin
          self_r  <= alu_y;
          state_r <= yield_hit ? S_YLD : S_RSRCH;
        end
        S_YLD: begin
          cur_r.yld <= alu_y;
          state_r   <= S_YSUM;
        end
        S_YSUM: begin
          ysum_r  <= alu_y;
          state_r <= S_RSRCH;
        end
        S_RSRCH: begin
          if (ri_r == cnt_r) begin
            if (cnt_r >= (RW+1)'(crtp_pkg::RECORD_ENTRIES)) begin
              st_r    <= crtp_pkg::ST_TBL_FULL;
              state_r <= S_PAR;
            end else begin
              rec_r   <= '{fn: cur_r.fn, line: cur_r.line, calls: '0, total: '0,
                           self_t: '0, coro: '0, tail: 1'b0};
              cnt_r   <= cnt_r + (RW+1)'(1);
              state_r <= S_CALLS;
            end
          end else begin
            state_r <= S_RCMP;
          end
        end
        S_RCMP: begin
          if (rm_rdata.fn == cur_r.fn) begin
            rec_r   <= rm_rdata;
            state_r <= S_CALLS;
          end else begin
            ri_r    <= ri_r + (RW+1)'(1);
            state_r <= S_RSRCH;
          end
        end
        S_CALLS: begin
          rec_r.calls <= alu_y[crtp_pkg::CALL_W-1:0];
          state_r     <= S_RTOT;
        end
        S_RTOT: begin
          rec_r.total <= alu_y;
          state_r     <= S_RSELF;
        end
        S_RSELF: begin
          rec_r.self_t <= alu_y;
          state_r      <= S_COR1;
        end
        S_COR1: begin
          rec_r.coro <= alu_y;
          state_r    <= S_COR2;
        end
        S_COR2: begin
          rec_r.coro <= alu_y;
          rec_r.tail <= rec_r.tail | cur_r.tail;
          state_r    <= S_WREC;
        end
        S_WREC: state_r <= S_PAR;
        S_PAR: state_r <= (depth_r == '0) ? S_SSUM : S_PLD;
        S_PLD: begin
          par_r   <= '{fn: fm_rdata.fn, line: fm_rdata.line, start: fm_rdata.start,
                       child: alu_y, yld: fm_rdata.yld, tail: fm_rdata.tail};
          state_r <= S_PYL;
        end
        S_PYL: begin
          par_r.yld <= alu_y;
          state_r   <= S_PWR;
        end
        S_PWR: state_r <= S_SSUM;
        S_SSUM: begin
          ssum_r <= alu_y;
          if (trace_r && cur_r.tail && depth_r != '0) begin
            depth_r <= depth_m1;
            cur_r   <= par_r;
            state_r <= S_TOT;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_st_r    <= st_r;
            out_data_r  <= {ysum_r, ssum_r, CNT_EXT(cnt_r), rd_rec_r.tail,
                            rd_rec_r.coro, rd_rec_r.self_t, rd_rec_r.total,
                            rd_rec_r.calls, rd_rec_r.line, rd_rec_r.fn};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/crtp_checker.sv -----
// ----------------------------------------------------------------------------
// crtp_checker
// port level checks of the call/return time profiler
// ----------------------------------------------------------------------------
module crtp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [327:0] out_tdata,
  input logic [2:0]   out_tuser
);

  // one event in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_entries_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[231:225] <= 7'd64)
    else $error("entries_used out of range");

  // record fields stay zero unless a read succeeded
  a_rec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != crtp_pkg::ST_OK |-> out_tdata[224:0] == '0)
    else $error("record fields set on failed event");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind call_return_time_profiler crtp_checker u_crtp_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
